### rtl/core/csba_pkg.sv
// Shared types and constants for the clipped sprite blitter.
// Used by every module of the block; no dependencies.
package csba_pkg;

  localparam int unsigned FRAME_COLS_DEF = 640;
  localparam int unsigned FRAME_ROWS_DEF = 480;

  localparam int unsigned PIX_W   = 16;
  localparam int unsigned ADDR_W  = 19;
  localparam int unsigned REG_W   = 11;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [PIX_W-1:0] ALPHA_MASK = 16'hF000;

  typedef enum logic [1:0] {
    REG_POS_X         = 2'd0,
    REG_POS_Y         = 2'd1,
    REG_SPRITE_WIDTH  = 2'd2,
    REG_SPRITE_HEIGHT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [REG_W-1:0] pos_x;
    logic [REG_W-1:0] pos_y;
    logic [REG_W-1:0] sprite_width;
    logic [REG_W-1:0] sprite_height;
  } cfg_t;

  typedef struct packed {
    logic s1_valid;
    logic hit;
  } pipe_sts_t;

endpackage

### rtl/core/csba_regs.sv
// APB configuration registers: sprite position and size.
// Depends on csba_pkg.
module csba_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csba_pkg::PADDR_W-1:0]  paddr,
  input  logic [csba_pkg::PDATA_W-1:0]  pwdata,
  output logic [csba_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output csba_pkg::cfg_t                cfg_o
);
  import csba_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_POS_X:         cfg_d.pos_x         = pwdata[REG_W-1:0];
        REG_POS_Y:         cfg_d.pos_y         = pwdata[REG_W-1:0];
        REG_SPRITE_WIDTH:  cfg_d.sprite_width  = pwdata[REG_W-1:0];
        REG_SPRITE_HEIGHT: cfg_d.sprite_height = pwdata[REG_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POS_X:         prdata = PDATA_W'(cfg_q.pos_x);
      REG_POS_Y:         prdata = PDATA_W'(cfg_q.pos_y);
      REG_SPRITE_WIDTH:  prdata = PDATA_W'(cfg_q.sprite_width);
      REG_SPRITE_HEIGHT: prdata = PDATA_W'(cfg_q.sprite_height);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_x         <= '0;
      cfg_q.pos_y         <= '0;
      cfg_q.sprite_width  <= REG_W'(1);
      cfg_q.sprite_height <= REG_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/core/csba_scan.sv
// Column and row counters that follow the raster position inside the sprite.
// Depends on csba_pkg.
module csba_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  csba_pkg::cfg_t              cfg_i,
  output logic [csba_pkg::CNT_W-1:0]  col_o,
  output logic [csba_pkg::CNT_W-1:0]  row_o
);
  import csba_pkg::*;

  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;
  logic [REG_W-1:0] col_inc, row_inc;
  logic             col_wrap, row_wrap;

  assign col_inc  = REG_W'(col_q) + REG_W'(1);
  assign row_inc  = REG_W'(row_q) + REG_W'(1);
  assign col_wrap = (col_inc >= cfg_i.sprite_width)  || (&col_q);
  assign row_wrap = (row_inc >= cfg_i.sprite_height) || (&row_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_inc[CNT_W-1:0];
      end else begin
        col_d = col_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o = col_q;
  assign row_o = row_q;

endmodule

### rtl/core/csba_pipe.sv
// Input register and result register with the clip, alpha and address logic.
// Depends on csba_pkg.
module csba_pipe #(
  parameter int unsigned FRAME_COLS = csba_pkg::FRAME_COLS_DEF,
  parameter int unsigned FRAME_ROWS = csba_pkg::FRAME_ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [csba_pkg::PIX_W-1:0]   pixel_i,
  input  csba_pkg::cfg_t               cfg_i,
  input  logic [csba_pkg::CNT_W-1:0]   col_i,
  input  logic [csba_pkg::CNT_W-1:0]   row_i,
  output logic                         accept_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [csba_pkg::ADDR_W-1:0]  write_address_o,
  output logic [csba_pkg::PIX_W-1:0]   write_data_o,
  output csba_pkg::pipe_sts_t          sts_o
);
  import csba_pkg::*;

  localparam int unsigned PROD_W = COORD_W + DIM_W;
  localparam logic [DIM_W-1:0] COLS = DIM_W'(FRAME_COLS);
  localparam logic [DIM_W-1:0] ROWS = DIM_W'(FRAME_ROWS);

  logic               s1_vld_q, out_vld_q;
  logic [PIX_W-1:0]   s1_pix_q, out_data_q;
  logic [COORD_W-1:0] s1_fx_q, s1_fy_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [COORD_W-1:0] fx_d, fy_d;
  logic               out_adv, s1_adv, hit, x_in, y_in;
  logic [PROD_W-1:0]  addr_full;

  assign out_adv    = !out_vld_q || !out_stall_i;
  assign s1_adv     = !s1_vld_q || out_adv;
  assign in_stall_o = !s1_adv;
  assign accept_o   = in_valid_i && s1_adv;

  assign fx_d = {cfg_i.pos_x[REG_W-1], cfg_i.pos_x} + COORD_W'(col_i);
  assign fy_d = {cfg_i.pos_y[REG_W-1], cfg_i.pos_y} + COORD_W'(row_i);

  assign x_in = !s1_fx_q[COORD_W-1] && (DIM_W'(s1_fx_q[COORD_W-2:0]) < COLS);
  assign y_in = !s1_fy_q[COORD_W-1] && (DIM_W'(s1_fy_q[COORD_W-2:0]) < ROWS);
  assign hit  = x_in && y_in && ((s1_pix_q & ALPHA_MASK) != '0);

  assign addr_full = PROD_W'(s1_fy_q[COORD_W-2:0]) * PROD_W'(COLS)
                   + PROD_W'(s1_fx_q[COORD_W-2:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_vld_q <= in_valid_i;
      end
      if (out_adv) begin
        out_vld_q <= s1_vld_q && hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      s1_pix_q <= pixel_i;
      s1_fx_q  <= fx_d;
      s1_fy_q  <= fy_d;
    end
    if (out_adv && s1_vld_q) begin
      out_addr_q <= addr_full[ADDR_W-1:0];
      out_data_q <= s1_pix_q;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign write_address_o = out_addr_q;
  assign write_data_o    = out_data_q;
  assign sts_o.s1_valid  = s1_vld_q;
  assign sts_o.hit       = hit;

endmodule

### rtl/core/clipped_sprite_blit_alpha.sv
// Sprite blitter with frame clipping and an alpha key.
// Top level; depends on csba_pkg, csba_regs, csba_scan and csba_pipe.
//
// Usage:
//   Sprite pixels arrive on pixel_i in raster order under in_valid_i and
//   in_stall_o. Each accepted request is placed at frame column
//   pos_x + column and frame row pos_y + row; the position counters wrap at
//   the configured sprite width and height, capped at 1024. A pixel inside
//   the frame with a nonzero alpha nibble yields one frame write on
//   write_address_o and write_data_o under out_valid_o and out_stall_i; any
//   other pixel yields nothing.
//   Each accepted request passes through the input register and then the
//   result register, where a visible pixel is presented under out_valid_o.
//   Throughput: one request per cycle unless the receiver stalls, set by the
//   two register stages (input register, result register) with the multiply-add
//   between them. When the receiver stalls, the result register holds and the
//   input register still fills, so in_stall_o rises once both stages are full.
//   Reset clears both stages and the counters, sets the position to 0 and
//   the sprite size to 1x1. Write the APB registers only while idle.
module clipped_sprite_blit_alpha #(
  parameter int unsigned FRAME_COLS = csba_pkg::FRAME_COLS_DEF,
  parameter int unsigned FRAME_ROWS = csba_pkg::FRAME_ROWS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [csba_pkg::PADDR_W-1:0] paddr,
  input  logic [csba_pkg::PDATA_W-1:0] pwdata,
  output logic [csba_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [csba_pkg::PIX_W-1:0]   pixel_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [csba_pkg::ADDR_W-1:0]  write_address_o,
  output logic [csba_pkg::PIX_W-1:0]   write_data_o
);
  import csba_pkg::*;

  localparam longint unsigned FRAME_PIX = longint'(FRAME_COLS) * longint'(FRAME_ROWS);
  localparam bit ADDR_FITS = FRAME_PIX <= (64'd1 << ADDR_W);

  cfg_t             cfg;
  pipe_sts_t        sts;
  logic             accept;
  logic [CNT_W-1:0] col, row;

  csba_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  csba_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (accept),
    .cfg_i     (cfg),
    .col_o     (col),
    .row_o     (row)
  );

  csba_pipe #(
    .FRAME_COLS (FRAME_COLS),
    .FRAME_ROWS (FRAME_ROWS)
  ) u_pipe (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pixel_i         (pixel_i),
    .cfg_i           (cfg),
    .col_i           (col),
    .row_i           (row),
    .accept_o        (accept),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .sts_o           (sts)
  );

  a_alpha_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((write_data_o & ALPHA_MASK) != '0))
    else $error("frame write with zero alpha");

  a_addr_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ADDR_FITS) |-> (64'(write_address_o) < FRAME_PIX))
    else $error("frame write outside the frame");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.s1_valid && out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("request accepted with both stages blocked");

  a_hit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts.s1_valid && sts.hit && !(out_valid_o && out_stall_i)) |=> out_valid_o)
    else $error("visible pixel lost between stages");

endmodule
